/* hdl/box_overlap_merge_unit_defines.svh */
// Assertion macros for the box overlap merge unit.
// Each macro takes a label, a condition and a consequence, sampled on clk.
`ifndef BOX_OVERLAP_MERGE_UNIT_DEFINES_SVH
`define BOX_OVERLAP_MERGE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BOMU_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box overlap merge: same-cycle check failed");
`define BOMU_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box overlap merge: next-cycle check failed");
`else
`define BOMU_ASSERT_IMP(name, ante, cons)
`define BOMU_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* hdl/bomu_pkg.sv */
package bomu_pkg;

	// Width of one box field on the stream ports
	localparam int FIELD_BITS = 16;
	// One bit more, for edge sums before saturation
	localparam int EXT_BITS = FIELD_BITS + 1;
	// Four fields packed in one word
	localparam int DATA_BITS = 4 * FIELD_BITS;

	// Defaults for the top level parameters
	localparam int DEF_MAX_BOXES = 64;
	localparam int DEF_COORD_BITS = 16;

endpackage

/* hdl/box_overlap_merge_unit.sv */
// Box overlap merge unit.
// Input stream (s_*): one box per word, tdata = {height, width, top, left}, tlast
// marks the final box of a list. Boxes are loaded at one word per cycle.
// After the tlast word the unit runs merge passes over the list until a pass
// keeps as many boxes as it read, then sends the kept boxes on the output
// stream (m_*): tdata = {height, width, top, left}, tlast on the final box,
// tuser = 1 when boxes beyond MAX_BOXES were discarded from that list.
// Boxes live in two single-port-read memories that swap roles each pass (read
// side / kept side). A pass reads each box in turn and compares it with the kept
// boxes one at a time, until it merges into one of them or is kept itself; one
// more pass runs after the last change.
// Results are read out one at a time, each read followed by its load into the
// output register. s_tready is low from the tlast word until the final result
// is loaded into the output register. A stalled receiver holds the output
// register and stops the result reads; no state is lost. Reset empties the
// list and the output register; memory contents need no clearing.
module box_overlap_merge_unit #(
	parameter int MAX_BOXES = bomu_pkg::DEF_MAX_BOXES,
	parameter int COORD_BITS = bomu_pkg::DEF_COORD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// box_left, box_top, box_width, box_height
	input  logic [bomu_pkg::DATA_BITS-1:0] s_tdata,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_left, out_top, out_width, out_height
	output logic [bomu_pkg::DATA_BITS-1:0] m_tdata,
	output logic                           m_tlast,
	// dropped
	output logic                           m_tuser
);

	`include "box_overlap_merge_unit_defines.svh"

	localparam int FB = bomu_pkg::FIELD_BITS;
	localparam int EB = bomu_pkg::EXT_BITS;
	localparam int CB = COORD_BITS;
	localparam int EW = 4 * CB;
	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam logic [EB-1:0] CMAX_E = EB'((1 << CB) - 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_BOXES);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_CUR,
		ST_SCAN,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	// Clip an extended edge to the coordinate range
	function automatic logic [CB-1:0] sat_c(input logic [EB-1:0] v);
		logic [CB-1:0] r;
		r = (v > CMAX_E) ? CMAX_E[CB-1:0] : v[CB-1:0];
		return r;
	endfunction

	// Inclusive span hi - lo + 1, saturated to a field
	function automatic logic [FB-1:0] span_f(input logic [CB-1:0] lo, input logic [CB-1:0] hi);
		logic [EB-1:0] s;
		s = EB'(hi) - EB'(lo) + EB'(1);
		return s[FB] ? {FB{1'b1}} : s[FB-1:0];
	endfunction

	state_t        state_q;
	logic [CW-1:0] in_cnt_q;
	logic          ovf_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] mc_q;
	logic [CW-1:0] jr_q;
	logic [AW-1:0] jc_q;
	logic          pend_q;
	logic [AW-1:0] k_q;
	logic          src_sel_q;

	logic                m_tvalid_q;
	logic [FB*4-1:0]     m_tdata_q;
	logic                m_tlast_q;
	logic                m_tuser_q;

	// Box memories: entry = {bottom, right, top, left}
	logic [EW-1:0] mem0 [MAX_BOXES];
	logic [EW-1:0] mem1 [MAX_BOXES];
	logic [EW-1:0] rd0_q, rd1_q;
	logic          we0, we1, re0, re1;
	logic [AW-1:0] wa, ra0, ra1;
	logic [EW-1:0] wd;

	logic          s_acc;
	logic [CB-1:0] in_l, in_t, in_r, in_b;
	logic [FB-1:0] in_w, in_h, in_wm1, in_hm1;
	logic [EW-1:0] in_ent;

	logic [EW-1:0] cur, kept;
	logic [CB-1:0] cur_l, cur_t, cur_r, cur_b;
	logic [CB-1:0] kp_l, kp_t, kp_r, kp_b;
	logic [EW-1:0] merged;
	logic          hit, last_chk, box_done, append;
	logic [CW-1:0] mc_nxt, i_nxt;
	logic          out_free, out_last;

	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;

	// Convert an incoming word to inclusive edges
	always_comb begin
		in_w   = s_tdata[2*FB +: FB];
		in_h   = s_tdata[3*FB +: FB];
		in_wm1 = (in_w == '0) ? '0 : in_w - FB'(1);
		in_hm1 = (in_h == '0) ? '0 : in_h - FB'(1);
		in_l   = sat_c(EB'(s_tdata[0 +: FB]));
		in_t   = sat_c(EB'(s_tdata[FB +: FB]));
		in_r   = sat_c(EB'(in_l) + EB'(in_wm1));
		in_b   = sat_c(EB'(in_t) + EB'(in_hm1));
		in_ent = {in_b, in_r, in_t, in_l};
	end

	// Split the read-side box and the kept box under test
	always_comb begin
		cur   = src_sel_q ? rd1_q : rd0_q;
		kept  = src_sel_q ? rd0_q : rd1_q;
		cur_l = cur[0 +: CB];
		cur_t = cur[CB +: CB];
		cur_r = cur[2*CB +: CB];
		cur_b = cur[3*CB +: CB];
		kp_l  = kept[0 +: CB];
		kp_t  = kept[CB +: CB];
		kp_r  = kept[2*CB +: CB];
		kp_b  = kept[3*CB +: CB];
		merged = {(kp_b > cur_b) ? kp_b : cur_b,
			(kp_r > cur_r) ? kp_r : cur_r,
			(kp_t < cur_t) ? kp_t : cur_t,
			(kp_l < cur_l) ? kp_l : cur_l};
		hit      = pend_q && (cur_r >= kp_l) && (kp_r >= cur_l);
		last_chk = pend_q && (jr_q == mc_q);
		box_done = hit || !pend_q || last_chk;
		append   = !hit && (!pend_q || last_chk);
		mc_nxt   = mc_q + CW'(append);
		i_nxt    = i_q + CW'(1);
		out_free = !m_tvalid_q || m_tready;
		out_last = (CW'(k_q) + CW'(1)) == mc_q;
	end

	// Drive the memory ports
	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		re0 = 1'b0;
		re1 = 1'b0;
		wa  = '0;
		wd  = in_ent;
		ra0 = '0;
		ra1 = '0;
		case (state_q)
			ST_LOAD: begin
				we0 = s_acc && (in_cnt_q < MAX_C);
				wa  = in_cnt_q[AW-1:0];
			end
			ST_RD_CUR: begin
				// read the next box and the first kept box together
				re0 = 1'b1;
				re1 = 1'b1;
				ra0 = src_sel_q ? '0 : i_q[AW-1:0];
				ra1 = src_sel_q ? i_q[AW-1:0] : '0;
			end
			ST_SCAN: begin
				if (hit) begin
					wa = jc_q;
					wd = merged;
				end else begin
					wa = mc_q[AW-1:0];
					wd = cur;
				end
				we0 = box_done && src_sel_q;
				we1 = box_done && !src_sel_q;
				re0 = !box_done && src_sel_q;
				re1 = !box_done && !src_sel_q;
				ra0 = jr_q[AW-1:0];
				ra1 = jr_q[AW-1:0];
			end
			ST_OUT_RD: begin
				re0 = out_free && src_sel_q;
				re1 = out_free && !src_sel_q;
				ra0 = k_q;
				ra1 = k_q;
			end
			default: begin
			end
		endcase
	end

	// Memory arrays with registered read data
	always_ff @(posedge clk) begin
		if (we0) mem0[wa] <= wd;
		if (re0) rd0_q <= mem0[ra0];
	end

	always_ff @(posedge clk) begin
		if (we1) mem1[wa] <= wd;
		if (re1) rd1_q <= mem1[ra1];
	end

	// Sequencer: load, merge passes, result readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			in_cnt_q   <= '0;
			ovf_q      <= 1'b0;
			n_q        <= '0;
			i_q        <= '0;
			mc_q       <= '0;
			jr_q       <= '0;
			jc_q       <= '0;
			pend_q     <= 1'b0;
			k_q        <= '0;
			src_sel_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// drop the output word once taken
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (in_cnt_q < MAX_C) begin
							in_cnt_q <= in_cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							n_q     <= (in_cnt_q < MAX_C) ? in_cnt_q + CW'(1) : in_cnt_q;
							i_q     <= '0;
							mc_q    <= '0;
							state_q <= ST_RD_CUR;
						end
					end
				end
				ST_RD_CUR: begin
					pend_q  <= (mc_q != '0);
					jc_q    <= '0;
					jr_q    <= CW'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (box_done) begin
						pend_q <= 1'b0;
						if (i_nxt != n_q) begin
							mc_q    <= mc_nxt;
							i_q     <= i_nxt;
							state_q <= ST_RD_CUR;
						end else if (mc_nxt == n_q) begin
							// pass left the count unchanged: read out
							mc_q    <= mc_nxt;
							k_q     <= '0;
							state_q <= ST_OUT_RD;
						end else begin
							// swap memories and run another pass
							n_q       <= mc_nxt;
							mc_q      <= '0;
							i_q       <= '0;
							src_sel_q <= !src_sel_q;
							state_q   <= ST_RD_CUR;
						end
					end else begin
						// advance the scan over kept boxes
						pend_q <= 1'b1;
						jc_q   <= jr_q[AW-1:0];
						jr_q   <= jr_q + CW'(1);
					end
				end
				ST_OUT_RD: begin
					if (out_free) state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					m_tvalid_q <= 1'b1;
					if (out_last) begin
						in_cnt_q  <= '0;
						ovf_q     <= 1'b0;
						mc_q      <= '0;
						src_sel_q <= 1'b0;
						state_q   <= ST_LOAD;
					end else begin
						k_q     <= k_q + AW'(1);
						state_q <= ST_OUT_RD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT_LD) begin
			m_tdata_q <= {span_f(kp_t, kp_b), span_f(kp_l, kp_r), FB'(kp_t), FB'(kp_l)};
			m_tlast_q <= out_last;
			m_tuser_q <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	`BOMU_ASSERT_IMP(a_kept_le_read, state_q == ST_SCAN, mc_q <= i_q)
	`BOMU_ASSERT_IMP(a_scan_in_range, (state_q == ST_SCAN) && pend_q, CW'(jc_q) < mc_q)
	`BOMU_ASSERT_NXT(a_last_starts_pass, s_acc && s_tlast, state_q == ST_RD_CUR)
	`BOMU_ASSERT_IMP(a_count_bound, 1'b1, (in_cnt_q <= MAX_C) && (n_q <= MAX_C))

endmodule

/* tb/sv/box_overlap_merge_unit_tb.sv */
module box_overlap_merge_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIELD_BITS = bomu_pkg::FIELD_BITS;
	localparam int DATA_BITS = bomu_pkg::DATA_BITS;
	localparam int CAPACITY = bomu_pkg::DEF_MAX_BOXES;
	localparam int unsigned COORD_MAX = (1 << bomu_pkg::DEF_COORD_BITS) - 1;
	localparam int unsigned SPAN_MAX = (1 << FIELD_BITS) - 1;
	// worst list: dozens of merge passes
	localparam int IDLE_LIMIT = 400000;
	localparam int RANDOM_BOXES = 220;
	localparam int TAIL_CYCLES = 64;

	typedef logic [FIELD_BITS-1:0] field_t;

	typedef struct {
		field_t left;
		field_t top;
		field_t width;
		field_t height;
		logic   last;
	} box_word_t;

	typedef struct {
		field_t left;
		field_t top;
		field_t width;
		field_t height;
		logic   last;
		logic   dropped;
	} merged_word_t;

	// inclusive edges, wide enough for unsaturated sums
	typedef struct {
		int unsigned l;
		int unsigned t;
		int unsigned r;
		int unsigned b;
	} span_box_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// box_left, box_top, box_width, box_height
	logic [DATA_BITS-1:0] s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	// out_left, out_top, out_width, out_height
	logic [DATA_BITS-1:0] m_tdata;
	logic                 m_tlast;
	// dropped
	logic                 m_tuser;

	span_box_t    pending_boxes[$];
	logic         pending_overflow = 1'b0;
	merged_word_t expected_boxes[$];

	int  boxes_sent = 0;
	int  lists_sent = 0;
	int  results_checked = 0;
	int  mismatch_count = 0;
	int  idle_cycles = 0;
	bit  src_active = 1'b0;
	bit  sink_active = 1'b0;
	bit  src_steady = 1'b0;
	bit  sink_steady = 1'b0;

	box_overlap_merge_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned clamp(int unsigned v, int unsigned lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic cols_touch(span_box_t a, span_box_t b);
		return (a.r >= b.l) && (b.r >= a.l);
	endfunction

	function automatic box_word_t make_box(int unsigned l, int unsigned t, int unsigned w,
			int unsigned h, bit last);
		box_word_t b;
		b.left = field_t'(l);
		b.top = field_t'(t);
		b.width = field_t'(w);
		b.height = field_t'(h);
		b.last = last;
		return b;
	endfunction

	// Absorb one accepted box; on the list's last word, merge and queue the kept boxes
	function automatic void predict_merge(box_word_t w);
		span_box_t    nb;
		span_box_t    src[$];
		span_box_t    kept[$];
		int unsigned  wd;
		int unsigned  ht;
		logic         hit;
		merged_word_t res;
		wd = (w.width == 0) ? 1 : w.width;
		ht = (w.height == 0) ? 1 : w.height;
		nb.l = clamp(w.left, COORD_MAX);
		nb.t = clamp(w.top, COORD_MAX);
		nb.r = clamp(nb.l + wd - 1, COORD_MAX);
		nb.b = clamp(nb.t + ht - 1, COORD_MAX);
		if (pending_boxes.size() < CAPACITY) begin
			pending_boxes.push_back(nb);
		end else begin
			pending_overflow = 1'b1;
		end
		if (!w.last) begin
			return;
		end
		// repeat passes until one keeps as many boxes as it read
		src = pending_boxes;
		forever begin
			kept.delete();
			foreach (src[i]) begin
				hit = 1'b0;
				foreach (kept[j]) begin
					if (!hit && cols_touch(src[i], kept[j])) begin
						kept[j].l = (src[i].l < kept[j].l) ? src[i].l : kept[j].l;
						kept[j].t = (src[i].t < kept[j].t) ? src[i].t : kept[j].t;
						kept[j].r = (src[i].r > kept[j].r) ? src[i].r : kept[j].r;
						kept[j].b = (src[i].b > kept[j].b) ? src[i].b : kept[j].b;
						hit = 1'b1;
					end
				end
				if (!hit) begin
					kept.push_back(src[i]);
				end
			end
			if (kept.size() == src.size()) begin
				break;
			end
			src = kept;
		end
		foreach (kept[i]) begin
			res.left = field_t'(kept[i].l);
			res.top = field_t'(kept[i].t);
			res.width = field_t'(clamp(kept[i].r - kept[i].l + 1, SPAN_MAX));
			res.height = field_t'(clamp(kept[i].b - kept[i].t + 1, SPAN_MAX));
			res.last = (i == kept.size() - 1);
			res.dropped = pending_overflow;
			expected_boxes.push_back(res);
		end
		pending_boxes.delete();
		pending_overflow = 1'b0;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		$display("%0d ns: mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(string name, field_t want, logic [FIELD_BITS-1:0] got);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
				results_checked, name, want, got));
		end
	endtask

	// Send one box word after a random gap, then predict its results
	task automatic send_box(box_word_t w);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0 && src_active) begin
			s_tvalid <= 1'b0;
			src_active = 1'b0;
		end
		repeat (gap) @(posedge clk);
		s_tvalid <= 1'b1;
		src_active = 1'b1;
		s_tdata <= {w.height, w.width, w.top, w.left};
		s_tlast <= w.last;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_merge(w);
		boxes_sent++;
		if (w.last) begin
			lists_sent++;
		end
	endtask

	// Hold the sender until every queued result has come back
	task automatic wait_for_results();
		if (src_active) begin
			s_tvalid <= 1'b0;
			src_active = 1'b0;
		end
		do @(posedge clk); while (expected_boxes.size() != 0);
	endtask

	// Send one list: mostly clustered columns so boxes merge, some fully random words
	task automatic send_random_list(int len);
		int unsigned spread;
		box_word_t   b;
		spread = ($urandom_range(0, 3) == 0) ? 60000 : $urandom_range(40, 1200);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				b.left = field_t'($urandom);
				b.top = field_t'($urandom);
				b.width = field_t'($urandom);
				b.height = field_t'($urandom);
			end else begin
				b.left = field_t'($urandom_range(0, spread));
				b.width = field_t'($urandom_range(0, 40));
				b.top = $urandom_range(0, 1) ? field_t'($urandom)
					: field_t'($urandom_range(0, 400));
				b.height = $urandom_range(0, 1) ? field_t'($urandom_range(0, 40))
					: field_t'($urandom);
			end
			b.last = (k == len - 1);
			send_box(b);
		end
	endtask

	task automatic test_directed();
		// smallest box
		send_box(make_box(0, 0, 1, 1, 1));
		// far corner: right and bottom edges saturate
		send_box(make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
		// zero width and height count as one pixel
		send_box(make_box(100, 200, 0, 0, 1));
		// full column span: output width saturates
		send_box(make_box(0, 0, 16'hFFFF, 16'hFFFF, 0));
		send_box(make_box(1, 1, 16'hFFFF, 16'hFFFF, 1));
		// alternating bit patterns in disjoint columns
		send_box(make_box(16'h5555, 16'hAAAA, 16'h2AAA, 16'h5555, 0));
		send_box(make_box(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1));
		// a shared column merges, adjacent columns do not
		send_box(make_box(0, 5, 10, 3, 0));
		send_box(make_box(9, 2, 10, 3, 0));
		send_box(make_box(19, 0, 10, 3, 1));
		// the third box bridges the first two, so a second pass is needed
		send_box(make_box(0, 50, 11, 5, 0));
		send_box(make_box(20, 10, 11, 5, 0));
		send_box(make_box(5, 100, 21, 3, 1));
		wait_for_results();
	endtask

	task automatic test_capacity();
		// disjoint list one past capacity: the tlast word itself is dropped
		for (int i = 0; i <= CAPACITY; i++) begin
			send_box(make_box(i * 1000, $urandom, $urandom_range(1, 999), $urandom,
				i == CAPACITY));
		end
		// overlapping list three boxes past capacity
		send_random_list(CAPACITY + 3);
		// the drop flag must clear with the list
		send_random_list(2);
		wait_for_results();
	endtask

	task automatic test_random();
		int random_boxes;
		int len;
		int lists;
		random_boxes = 0;
		lists = 0;
		while (random_boxes < RANDOM_BOXES) begin
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			src_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			send_random_list(len);
			random_boxes += len;
			lists++;
			// drain now and then, so the sender sits idle while results leave
			if (lists % 8 == 0) begin
				wait_for_results();
			end
		end
	endtask

	// Drive tready with a random stall before each result word
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 9);
			if (stall > 0 && sink_active) begin
				m_tready <= 1'b0;
				sink_active = 1'b0;
			end
			repeat (stall) @(posedge clk);
			if (!sink_active) begin
				m_tready <= 1'b1;
				sink_active = 1'b1;
			end
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	// Compare each accepted result word with the oldest expected box
	always @(posedge clk) begin : result_check
		merged_word_t want;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (expected_boxes.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no box expected",
					results_checked));
			end else begin
				want = expected_boxes.pop_front();
				compare_field("left", want.left, m_tdata[0 +: FIELD_BITS]);
				compare_field("top", want.top, m_tdata[FIELD_BITS +: FIELD_BITS]);
				compare_field("width", want.width, m_tdata[2*FIELD_BITS +: FIELD_BITS]);
				compare_field("height", want.height, m_tdata[3*FIELD_BITS +: FIELD_BITS]);
				compare_field("last", field_t'(want.last), field_t'(m_tlast));
				compare_field("dropped", field_t'(want.dropped), field_t'(m_tuser));
			end
			results_checked++;
		end
	end

	// End the run when no word moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid === 1'b1 && s_tready === 1'b1)
				|| (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("box_overlap_merge_unit_tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_capacity();
		test_random();

		// let any stray result show up before judging
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d lists of %0d boxes, %0d merged boxes checked",
			lists_sent, boxes_sent, results_checked);
		$display("edge cases, capacity overflow, multi-pass merges; %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0 && expected_boxes.size() == 0) begin
			$display("box_overlap_merge_unit_tb: PASS");
		end else begin
			$display("box_overlap_merge_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
